### rtl/rtpd_pkg.sv
package rtpd_pkg;

  localparam int MaxResults = 7;
  localparam int CntW       = 3;
  localparam int PosW       = 19;

  localparam logic [PosW-1:0] PosMax      = {PosW{1'b1}};
  localparam logic [PosW-1:0] FixedHdrLen = 19'd12;

  // packet kind codes
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindSingle = 2'd1;
  localparam logic [1:0] KindFrag   = 2'd2;
  localparam logic [1:0] KindAggr   = 2'd3;

  // nal unit types that select fragment or aggregation handling
  localparam logic [4:0] H264FuA  = 5'd28;
  localparam logic [4:0] H264StapA = 5'd24;
  localparam logic [5:0] H265Fu   = 6'd49;
  localparam logic [5:0] H265Ap   = 6'd48;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       unit_end;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0]             cnt;
    entry_t [MaxResults-1:0]     ent;
  } parse_out_t;

endpackage

### rtl/rtpd_parse.sv
module rtpd_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [7:0]             pkt_byte,
  input  logic                   last_byte,
  input  logic                   codec_h265,
  output rtpd_pkg::parse_out_t   pout
);

  logic [rtpd_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [rtpd_pkg::PosW-1:0] pstart_r, pstart_nxt;
  logic                      ext_r, ext_nxt;
  logic                      marker_r, marker_nxt;
  logic [7:0]                first_r, first_nxt;
  logic [7:0]                second_r, second_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic                      nonempty_r, nonempty_nxt;

  logic [rtpd_pkg::PosW-1:0] ps_v;
  logic [rtpd_pkg::PosW-1:0] off;
  logic                      ext_v;
  logic                      marker_v;
  logic [7:0]                first_v;
  logic [7:0]                second_v;
  logic [1:0]                kind_v;
  logic                      in_pay;
  logic                      pre;
  logic [7:0]                d0, d1;
  logic [1:0]                nd;
  logic [rtpd_pkg::CntW-1:0] nb;
  logic                      usable;
  logic                      endf;
  logic [7:0]                seq [rtpd_pkg::MaxResults];

  always_comb begin
    ps_v     = pstart_r;
    ext_v    = ext_r;
    marker_v = marker_r;
    second_v = second_r;
    first_v  = first_r;
    kind_v   = kind_r;
    in_pay   = 1'b0;
    off      = '0;
    pre      = 1'b0;
    d0       = pkt_byte;
    d1       = 8'h00;
    nd       = 2'd0;

    if (pos_r == '0) begin
      ps_v  = rtpd_pkg::FixedHdrLen + {13'd0, pkt_byte[3:0], 2'b00};
      ext_v = pkt_byte[4];
    end else if (pos_r == 19'd1) begin
      marker_v = pkt_byte[7];
    end

    // extension header: length sits in its third and fourth bytes
    if (ext_v && pos_r != '0) begin
      if (pos_r == ps_v + 19'd2) begin
        second_v = pkt_byte;
      end else if (pos_r == ps_v + 19'd3) begin
        ps_v     = ps_v + 19'd4 + {1'b0, second_r, pkt_byte, 2'b00};
        ext_v    = 1'b0;
        second_v = 8'h00;
      end
    end else if (!ext_v && pos_r >= ps_v) begin
      in_pay = 1'b1;
      off    = pos_r - ps_v;
    end

    if (in_pay) begin
      if (off == '0) begin
        first_v = pkt_byte;
        if (!codec_h265) begin
          kind_v = (pkt_byte[4:0] == rtpd_pkg::H264FuA)   ? rtpd_pkg::KindFrag :
                   (pkt_byte[4:0] == rtpd_pkg::H264StapA) ? rtpd_pkg::KindAggr :
                                                            rtpd_pkg::KindSingle;
        end else begin
          kind_v = (pkt_byte[6:1] == rtpd_pkg::H265Fu) ? rtpd_pkg::KindFrag :
                   (pkt_byte[6:1] == rtpd_pkg::H265Ap) ? rtpd_pkg::KindAggr :
                                                         rtpd_pkg::KindSingle;
        end
        if (kind_v == rtpd_pkg::KindSingle) begin
          pre = 1'b1;
          nd  = 2'd1;
        end
      end else if (kind_r == rtpd_pkg::KindSingle) begin
        nd = 2'd1;
      end else if (kind_r == rtpd_pkg::KindFrag) begin
        if (off == 19'd1) begin
          second_v = pkt_byte;
        end
        if (!codec_h265) begin
          if (off == 19'd1) begin
            if (pkt_byte[7]) begin
              pre = 1'b1;
              nd  = 2'd1;
              d0  = (first_r & 8'hE0) | (pkt_byte & 8'h1F);
            end
          end else begin
            nd = 2'd1;
          end
        end else begin
          if (off == 19'd2) begin
            if (pkt_byte[7]) begin
              pre = 1'b1;
              nd  = 2'd2;
              d0  = (first_r & 8'h81) | {1'b0, pkt_byte[5:0], 1'b0};
              d1  = second_r;
            end
          end else if (off > 19'd2) begin
            nd = 2'd1;
          end
        end
      end
    end

    nb = pre ? (3'd4 + {1'b0, nd}) : {1'b0, nd};

    // a fragment too short for its fu bytes does not close the unit
    usable = in_pay;
    if (usable && kind_v == rtpd_pkg::KindFrag) begin
      usable = codec_h265 ? (off >= 19'd2) : (off >= 19'd1);
    end
    endf = last_byte && usable && marker_v && (nonempty_r || nb != '0);

    seq[0] = pre ? 8'h00 : d0;
    seq[1] = pre ? 8'h00 : d1;
    seq[2] = 8'h00;
    seq[3] = pre ? 8'h01 : 8'h00;
    seq[4] = d0;
    seq[5] = d1;
    seq[6] = 8'h00;

    for (int i = 0; i < rtpd_pkg::MaxResults; i++) begin
      pout.ent[i] = '0;
      if (3'(i) < nb) begin
        pout.ent[i].data = seq[i];
        pout.ent[i].has  = 1'b1;
      end else if (3'(i) == nb && endf) begin
        pout.ent[i].unit_end = 1'b1;
      end
    end
    pout.cnt = nb + {2'b00, endf};

    nonempty_nxt = endf ? 1'b0 : (nonempty_r || nb != '0);

    if (last_byte) begin
      pos_nxt    = '0;
      pstart_nxt = rtpd_pkg::FixedHdrLen;
      ext_nxt    = 1'b0;
      marker_nxt = 1'b0;
      first_nxt  = 8'h00;
      second_nxt = 8'h00;
      kind_nxt   = rtpd_pkg::KindNone;
    end else begin
      pos_nxt    = (pos_r == rtpd_pkg::PosMax) ? pos_r : pos_r + 19'd1;
      pstart_nxt = ps_v;
      ext_nxt    = ext_v;
      marker_nxt = marker_v;
      first_nxt  = first_v;
      second_nxt = second_v;
      kind_nxt   = kind_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pstart_r   <= rtpd_pkg::FixedHdrLen;
      ext_r      <= 1'b0;
      marker_r   <= 1'b0;
      first_r    <= 8'h00;
      second_r   <= 8'h00;
      kind_r     <= rtpd_pkg::KindNone;
      nonempty_r <= 1'b0;
    end else if (take) begin
      pos_r      <= pos_nxt;
      pstart_r   <= pstart_nxt;
      ext_r      <= ext_nxt;
      marker_r   <= marker_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      kind_r     <= kind_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

### rtl/rtp_h264_h265_depayloader.sv
// RTP to Annex B depayloader for H.264 and H.265. Packet bytes enter one per
// transaction on the in_ channel with in_tlast on the final byte; the fixed
// header, CSRC list and header extension are skipped, single NAL units get a
// 00 00 00 01 start code, fragmentation units are reassembled with a rebuilt
// NAL header and aggregation packets are dropped. A marker packet with a
// usable payload closes a non-empty access unit with an end-only transaction
// (out_tuser[1] set, out_tuser[0] clear). Each input byte yields 0 to 7
// output transactions, out_tlast marking the last of them. A byte passes an
// input register and the parse logic into a 7-entry result shift register;
// the byte waits in the input register until the result register empties.
// The result register drains one entry per cycle while out_tready is high
// and takes the next byte's results in the cycle it empties, so a byte holds
// the input until its last result is taken (5 results at a start code, 6 at
// an H.265 fragment start, plus 1 when an access unit ends there).
// cfg_wr_data[0] selects H.265 (1) or H.264 (0) rules; write it only while idle.
module rtp_h264_h265_depayloader (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // codec_is_h265
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] packet_byte
  input  logic       in_tlast,      // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic [1:0] out_tuser,     // [0] has_byte, [1] unit_end
  output logic       out_tlast      // run_last
);

  logic                      h265_r;
  logic                      in_vld_r;
  logic [7:0]                in_byte_r;
  logic                      in_last_r;
  rtpd_pkg::entry_t [rtpd_pkg::MaxResults-1:0] ent_r;
  logic [rtpd_pkg::CntW-1:0] cnt_r;

  rtpd_pkg::parse_out_t      pout;
  logic                      burst_free;
  logic                      take;
  logic                      out_fire;

  assign out_fire   = out_tvalid && out_tready;
  assign burst_free = (cnt_r == '0) || (cnt_r == 3'd1 && out_tready);
  assign take       = in_vld_r && burst_free;
  assign in_tready  = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h265_r <= 1'b0;
    end else if (cfg_wr_en) begin
      h265_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  rtpd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .pkt_byte   (in_byte_r),
    .last_byte  (in_last_r),
    .codec_h265 (h265_r),
    .pout       (pout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= pout.cnt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= pout.ent;
    end else if (out_fire) begin
      for (int i = 0; i < rtpd_pkg::MaxResults - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
      ent_r[rtpd_pkg::MaxResults-1] <= '0;
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = ent_r[0].data;
  assign out_tuser  = {ent_r[0].unit_end, ent_r[0].has};
  assign out_tlast  = (cnt_r == 3'd1);

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(rtpd_pkg::MaxResults))
    else $error("result count above maximum");

  a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == 8'h00 && out_tlast)
    else $error("unit end item carries data or is not last");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take && pout.cnt != '0 |=> out_tvalid)
    else $error("loaded results not presented");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tlast |=> out_tvalid && !$past(take))
    else $error("run broken before its last result");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int DrainCycles = 16;
  localparam int MaxPrinted  = 40;
  localparam int HoldCycles  = 60;
  localparam int PhaseBytes  = 16;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       uend;
    logic       last;
  } annexb_item_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = 8'h00;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  rtp_h264_h265_depayloader uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // expected annex b stream and depacketizer state mirror
  annexb_item_t              annexb_q[$];
  logic                      codec_h265;
  logic [rtpd_pkg::PosW-1:0] pkt_pos;
  logic [rtpd_pkg::PosW-1:0] pl_start;
  logic                      ext_pending;
  logic                      marker;
  logic [7:0]                nal_hdr;
  logic [7:0]                second_byte;
  logic [1:0]                kind;
  logic                      unit_open;
  int                        step_n;

  int errors      = 0;
  int n_sent      = 0;
  int n_packets   = 0;
  int n_results   = 0;
  int n_units     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req    = 0;
  int hold_left   = 0;

  logic [7:0] pkt_q[$];

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #200000;
    $display("timeout with %0d output transactions still expected", annexb_q.size());
    $display("rtp_h264_h265_depayloader: mismatch");
    $finish;
  end

  function automatic void clear_packet_state();
    pkt_pos     = '0;
    pl_start    = rtpd_pkg::FixedHdrLen;
    ext_pending = 1'b0;
    marker      = 1'b0;
    nal_hdr     = 8'h00;
    second_byte = 8'h00;
    kind        = rtpd_pkg::KindNone;
  endfunction

  function automatic void reset_mirror();
    codec_h265 = 1'b0;
    unit_open  = 1'b0;
    clear_packet_state();
  endfunction

  function automatic void emit(logic [7:0] d, logic has, logic uend);
    annexb_item_t it;
    it.data = d;
    it.has  = has;
    it.uend = uend;
    it.last = 1'b0;
    annexb_q.push_back(it);
    if (has) unit_open = 1'b1;
    step_n++;
  endfunction

  function automatic void emit_start_code();
    emit(8'h00, 1'b1, 1'b0);
    emit(8'h00, 1'b1, 1'b0);
    emit(8'h00, 1'b1, 1'b0);
    emit(8'h01, 1'b1, 1'b0);
  endfunction

  function automatic void predict_annexb(logic [7:0] b, logic l);
    logic [rtpd_pkg::PosW-1:0] p;
    logic [rtpd_pkg::PosW-1:0] off;
    logic                      in_pl;
    logic                      usable;
    annexb_item_t              tail;
    p      = pkt_pos;
    off    = '0;
    in_pl  = 1'b0;
    step_n = 0;

    if (p == '0) begin
      pl_start    = rtpd_pkg::FixedHdrLen + {13'd0, b[3:0], 2'b00};
      ext_pending = b[4];
    end else if (p == 19'd1) begin
      marker = b[7];
    end

    // the extension length high byte is parked in second_byte until the low byte arrives
    if (ext_pending && p != '0) begin
      if (p == pl_start + 19'd2) begin
        second_byte = b;
      end else if (p == pl_start + 19'd3) begin
        pl_start    = pl_start + 19'd4 + {1'b0, second_byte, b, 2'b00};
        ext_pending = 1'b0;
        second_byte = 8'h00;
      end
    end else if (!ext_pending && p >= pl_start) begin
      in_pl = 1'b1;
      off   = p - pl_start;
    end

    if (in_pl) begin
      if (off == '0) begin
        nal_hdr = b;
        if (!codec_h265) begin
          kind = (b[4:0] == rtpd_pkg::H264FuA)   ? rtpd_pkg::KindFrag :
                 (b[4:0] == rtpd_pkg::H264StapA) ? rtpd_pkg::KindAggr : rtpd_pkg::KindSingle;
        end else begin
          kind = (b[6:1] == rtpd_pkg::H265Fu) ? rtpd_pkg::KindFrag :
                 (b[6:1] == rtpd_pkg::H265Ap) ? rtpd_pkg::KindAggr : rtpd_pkg::KindSingle;
        end
        if (kind == rtpd_pkg::KindSingle) begin
          emit_start_code();
          emit(b, 1'b1, 1'b0);
        end
      end else if (kind == rtpd_pkg::KindSingle) begin
        emit(b, 1'b1, 1'b0);
      end else if (kind == rtpd_pkg::KindFrag) begin
        if (off == 19'd1) second_byte = b;
        if (!codec_h265) begin
          if (off == 19'd1) begin
            if (b[7]) begin
              emit_start_code();
              emit({nal_hdr[7:5], b[4:0]}, 1'b1, 1'b0);
            end
          end else begin
            emit(b, 1'b1, 1'b0);
          end
        end else begin
          if (off == 19'd2) begin
            if (b[7]) begin
              emit_start_code();
              emit({nal_hdr[7], b[5:0], nal_hdr[0]}, 1'b1, 1'b0);
              emit(second_byte, 1'b1, 1'b0);
            end
          end else if (off > 19'd2) begin
            emit(b, 1'b1, 1'b0);
          end
        end
      end
    end

    if (l) begin
      usable = in_pl;
      if (usable && kind == rtpd_pkg::KindFrag) begin
        usable = codec_h265 ? (off >= 19'd2) : (off >= 19'd1);
      end
      if (usable && marker && unit_open) begin
        emit(8'h00, 1'b0, 1'b1);
        unit_open = 1'b0;
        n_units++;
      end
      clear_packet_state();
    end else if (pkt_pos != rtpd_pkg::PosMax) begin
      pkt_pos = pkt_pos + 19'd1;
    end

    if (step_n > 0) begin
      tail      = annexb_q.pop_back();
      tail.last = 1'b1;
      annexb_q.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) $display("[%0t] error: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    annexb_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (annexb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction data %02h user %b last %b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = annexb_q.pop_front();
        if (out_tdata !== want.data || out_tuser[0] !== want.has ||
            out_tuser[1] !== want.uend || out_tlast !== want.last) begin
          report_mismatch($sformatf(
            "got data %02h has %b end %b last %b, expected %02h %b %b %b",
            out_tdata, out_tuser[0], out_tuser[1], out_tlast,
            want.data, want.has, want.uend, want.last));
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rnd_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    predict_annexb(b, l);
    n_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    if (pkt_q.size() != 0) n_packets++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_codec(input logic h265);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h265;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    codec_h265 = h265;
  endtask

  // fixed header, csrc list and optional extension; ignored bits are random
  task automatic start_packet(input int cc, input logic x, input logic m,
                              input logic [15:0] ext_words);
    logic [31:0] r;
    r = $urandom;
    pkt_q.delete();
    pkt_q.push_back({r[2:0], x, cc[3:0]});
    pkt_q.push_back({m, r[9:3]});
    repeat (10) pkt_q.push_back(rnd_byte());
    repeat (4 * cc) pkt_q.push_back(rnd_byte());
    if (x) begin
      pkt_q.push_back(rnd_byte());
      pkt_q.push_back(rnd_byte());
      pkt_q.push_back(ext_words[15:8]);
      pkt_q.push_back(ext_words[7:0]);
      repeat (4 * int'(ext_words)) pkt_q.push_back(rnd_byte());
    end
  endtask

  task automatic add_random(input int n);
    repeat (n) pkt_q.push_back(rnd_byte());
  endtask

  task automatic cut_packet(input int n);
    while (pkt_q.size() > n) void'(pkt_q.pop_back());
  endtask

  task automatic test_single_nal();
    set_codec(1'b0);
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h65);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hFF);
    send_packet();
    // marker with no payload must not close anything
    start_packet(0, 1'b0, 1'b1, 16'd0);
    send_packet();
  endtask

  task automatic test_fragments_h264();
    set_codec(1'b0);
    // start fragment with no data bytes
    start_packet(0, 1'b0, 1'b0, 16'd0);
    pkt_q.push_back(8'h7C);
    pkt_q.push_back(8'h85);
    send_packet();
    // fragment cut before its fu header, marker ignored
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h7C);
    send_packet();
    // aggregation with marker closes the open unit
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h78);
    send_packet();
    // continuation fragment with its data, closed by the marker
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h7C);
    pkt_q.push_back(8'h45);
    pkt_q.push_back(8'h44);
    send_packet();
  endtask

  task automatic test_header_skip();
    set_codec(1'b0);
    // packet ending inside the fixed header
    start_packet(0, 1'b0, 1'b1, 16'd0);
    cut_packet(6);
    send_packet();
    // csrc word and a one-word extension ahead of the payload
    start_packet(1, 1'b1, 1'b1, 16'd1);
    pkt_q.push_back(8'h41);
    pkt_q.push_back(8'h9A);
    send_packet();
    // extension length with a nonzero high byte, packet ends inside the extension
    start_packet(0, 1'b1, 1'b1, 16'h0100);
    cut_packet(20);
    send_packet();
  endtask

  task automatic test_h265();
    set_codec(1'b1);
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h62);
    pkt_q.push_back(8'h01);
    pkt_q.push_back(8'h93);
    pkt_q.push_back(8'hCC);
    send_packet();
  endtask

  // receiver holds off while a single nal packet keeps coming
  task automatic test_backpressure();
    set_codec(1'b0);
    hold_req = HoldCycles;
    start_packet(0, 1'b0, 1'b1, 16'd0);
    pkt_q.push_back(8'h65);
    add_random(5);
    send_packet();
  endtask

  task automatic build_random_packet();
    int         cc;
    int         sel;
    logic       x;
    logic       m;
    logic       s;
    logic [7:0] r;
    cc = $urandom_range(0, 1);
    x  = ($urandom_range(3) == 0);
    m  = 1'($urandom_range(1));
    start_packet(cc, x, m, 16'($urandom_range(0, 1)));
    sel = $urandom_range(99);
    r   = rnd_byte();
    if (sel < 35) begin
      if (!codec_h265) begin
        pkt_q.push_back((r[4:0] == rtpd_pkg::H264FuA || r[4:0] == rtpd_pkg::H264StapA) ?
                        (r ^ 8'h01) : r);
      end else begin
        pkt_q.push_back((r[6:1] == rtpd_pkg::H265Fu || r[6:1] == rtpd_pkg::H265Ap) ?
                        (r ^ 8'h04) : r);
      end
      add_random($urandom_range(0, 8));
    end else if (sel < 80) begin
      s = ($urandom_range(99) < 40);
      if (!codec_h265) begin
        pkt_q.push_back({r[7:5], rtpd_pkg::H264FuA});
      end else begin
        pkt_q.push_back({r[7], rtpd_pkg::H265Fu, r[0]});
        pkt_q.push_back(rnd_byte());
      end
      r = rnd_byte();
      pkt_q.push_back({s, r[6:0]});
      add_random($urandom_range(0, 8));
    end else if (sel < 90) begin
      if (!codec_h265) pkt_q.push_back({r[7:5], rtpd_pkg::H264StapA});
      else pkt_q.push_back({r[7], rtpd_pkg::H265Ap, r[0]});
      add_random($urandom_range(0, 8));
    end else begin
      add_random($urandom_range(0, 6));
    end
    if ($urandom_range(9) == 0) cut_packet(int'($urandom_range(1, pkt_q.size())));
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input logic h265);
    int base;
    set_codec(h265);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    base = n_sent;
    while (n_sent - base < PhaseBytes) begin
      build_random_packet();
      send_packet();
    end
  endtask

  initial begin
    reset_mirror();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 48;
    test_single_nal();
    test_fragments_h264();
    test_header_skip();
    test_h265();
    test_backpressure();
    test_random_traffic(48, 31, 1'b1);
    test_random_traffic(0, 0, 1'($urandom_range(1)));
    wait_idle();

    $display("sent %0d packets (%0d bytes) under both codecs, checked %0d output transactions",
             n_packets, n_sent, n_results);
    $display("closed %0d access units; %0d mismatches", n_units, errors);
    if (errors == 0) begin
      $display("rtp_h264_h265_depayloader: match");
    end else begin
      $display("rtp_h264_h265_depayloader: mismatch");
    end
    $finish;
  end

endmodule

### rtp_h264_h265_depayloader.f
rtl/rtpd_pkg.sv
rtl/rtpd_parse.sv
rtl/rtp_h264_h265_depayloader.sv
dv/tb.sv
